>>> src/lte_pkg.sv
// Shared types and constants for the line text edit engine.
package lte_pkg;

  localparam int MAX_LINES     = 64;
  localparam int LINE_CAPACITY = 128;
  localparam int ROW_W         = 6;
  localparam int COL_W         = 7;
  localparam int LINES_W       = 7;
  localparam int CHAR_W        = 7;
  localparam int KEY_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int ADDR_W        = ROW_W + COL_W;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [KEY_W-1:0] KEY_ENTER       = 8'd10;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE   = 8'd8;
  localparam logic [KEY_W-1:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [KEY_W-1:0] PAST_PRINTABLE  = 8'd127;

  localparam logic [KEY_W-1:0] LEFT_RESET  = 8'd17;
  localparam logic [KEY_W-1:0] RIGHT_RESET = 8'd18;
  localparam logic [KEY_W-1:0] UP_RESET    = 8'd19;
  localparam logic [KEY_W-1:0] DOWN_RESET  = 8'd20;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAN = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT  = 2'd0,
    CFG_RIGHT = 2'd1,
    CFG_UP    = 2'd2,
    CFG_DOWN  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    K_NOP, K_ENTER, K_BKSP, K_LEFT, K_RIGHT, K_UP, K_DOWN, K_INS,
    K_CLEAR, K_READ, K_CLEAN
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic               changed;
    logic [ROW_W-1:0]   cursor_line;
    logic [COL_W-1:0]   cursor_column;
    logic [LINES_W-1:0] lines_in_use;
    logic               modified;
    logic [CHAR_W-1:0]  read_char;
    logic [COL_W-1:0]   read_line_length;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_P0, S_P1, S_P2, S_P3, S_EXEC, S_RDW, S_MRD, S_MWR,
    S_CRD, S_CWR, S_FIN, S_FIN2, S_OUT
  } state_t;

endpackage

>>> src/line_text_edit_engine.sv
// Top level of the line text edit engine.
//
// Requests enter on start with in_opcode, in_key_code, in_read_row and
// in_read_column; one is taken at each clock edge with start high and busy
// low. busy rises only when the two-entry request queue is full.
// Every request gives exactly one result, shown for one cycle with
// out_strobe high; the receiver takes it then and cannot stall.
// The arrow key codes are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high.
// Edits walk the text memory one moved character at a time and the line
// map one shifted line at a time, so enter or a backspace that joins two
// lines both moves characters and shifts the line map, while typing or a
// backspace inside a line only moves characters.
// Requests are carried out one at a time in order.
// Reset gives one empty line, cursor at 0/0, clean buffer, default arrow
// codes and an empty queue; no clearing pass is needed.
module line_text_edit_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [lte_pkg::KEY_W-1:0]     in_key_code,
  input  logic [lte_pkg::ROW_W-1:0]     in_read_row,
  input  logic [lte_pkg::COL_W-1:0]     in_read_column,
  output logic                          out_strobe,
  output logic                          out_changed,
  output logic [lte_pkg::ROW_W-1:0]     out_cursor_line,
  output logic [lte_pkg::COL_W-1:0]     out_cursor_column,
  output logic [lte_pkg::LINES_W-1:0]   out_lines_in_use,
  output logic                          out_modified,
  output logic [lte_pkg::CHAR_W-1:0]    out_read_char,
  output logic [lte_pkg::COL_W-1:0]     out_read_line_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lte_pkg::KEY_W-1:0]     cfg_data
);
  import lte_pkg::*;

  logic    push, pop, q_empty, q_full;
  cmd_t    push_cmd, pop_cmd;
  result_t res;

  assign busy = q_full;

  lte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .q_full         (q_full),
    .in_opcode      (in_opcode),
    .in_key_code    (in_key_code),
    .in_read_row    (in_read_row),
    .in_read_column (in_read_column),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .cmd            (push_cmd)
  );

  lte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  lte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .res_strobe (out_strobe),
    .res        (res)
  );

  assign out_changed          = res.changed;
  assign out_cursor_line      = res.cursor_line;
  assign out_cursor_column    = res.cursor_column;
  assign out_lines_in_use     = res.lines_in_use;
  assign out_modified         = res.modified;
  assign out_read_char        = res.read_char;
  assign out_read_line_length = res.read_line_length;

endmodule

>>> src/lte_front.sv
// Front end: key code registers and request classification.
module lte_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          q_full,
  input  logic [1:0]                    in_opcode,
  input  logic [lte_pkg::KEY_W-1:0]     in_key_code,
  input  logic [lte_pkg::ROW_W-1:0]     in_read_row,
  input  logic [lte_pkg::COL_W-1:0]     in_read_column,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lte_pkg::KEY_W-1:0]     cfg_data,
  output logic                          push,
  output lte_pkg::cmd_t                 cmd
);
  import lte_pkg::*;

  logic [KEY_W-1:0] left_r, right_r, up_r, down_r;

  assign cfg_ready = 1'b1;

  // Hold the arrow key codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= LEFT_RESET;
      right_r <= RIGHT_RESET;
      up_r    <= UP_RESET;
      down_r  <= DOWN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT:  left_r  <= cfg_data;
        CFG_RIGHT: right_r <= cfg_data;
        CFG_UP:    up_r    <= cfg_data;
        CFG_DOWN:  down_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign push = start && !q_full;

  // Classify the request; enter and backspace win over the arrow codes
  always_comb begin
    cmd.ch  = in_key_code[CHAR_W-1:0];
    cmd.row = in_read_row;
    cmd.col = in_read_column;
    unique case (opcode_t'(in_opcode))
      OP_KEY: begin
        if (in_key_code == KEY_ENTER)          cmd.kind = K_ENTER;
        else if (in_key_code == KEY_BACKSPACE) cmd.kind = K_BKSP;
        else if (in_key_code == left_r)        cmd.kind = K_LEFT;
        else if (in_key_code == right_r)       cmd.kind = K_RIGHT;
        else if (in_key_code == up_r)          cmd.kind = K_UP;
        else if (in_key_code == down_r)        cmd.kind = K_DOWN;
        else if (in_key_code >= FIRST_PRINTABLE && in_key_code < PAST_PRINTABLE)
          cmd.kind = K_INS;
        else                                   cmd.kind = K_NOP;
      end
      OP_CLEAR: cmd.kind = K_CLEAR;
      OP_READ:  cmd.kind = K_READ;
      OP_CLEAN: cmd.kind = K_CLEAN;
      default:  cmd.kind = K_NOP;
    endcase
  end

endmodule

>>> src/lte_queue.sv
// Short request queue between the front end and the edit sequencer.
module lte_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lte_pkg::cmd_t push_cmd,
  input  logic          pop,
  output lte_pkg::cmd_t pop_cmd,
  output logic          empty,
  output logic          full
);
  import lte_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_cmd = mem_r[rd_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

endmodule

>>> src/lte_back.sv
// Edit sequencer: line map, line lengths, text memory and cursor state.
module lte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  lte_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             res_strobe,
  output lte_pkg::result_t res
);
  import lte_pkg::*;

  // memories: text, logical row to physical slot map, lengths per slot
  logic [CHAR_W-1:0] txt_mem [MAX_LINES*LINE_CAPACITY];
  logic [ROW_W-1:0]  map_mem [MAX_LINES];
  logic [COL_W-1:0]  len_mem [MAX_LINES];
  logic [MAX_LINES-1:0] map_vld_r, len_vld_r;

  logic [CHAR_W-1:0] txt_q_r;
  logic [ROW_W-1:0]  map_q_r, map_qa_r;
  logic              map_qv_r;
  logic [COL_W-1:0]  len_q_r;
  logic              len_qv_r;

  logic              txt_we, map_we, len_we, len_clr;
  logic [ADDR_W-1:0] txt_raddr, txt_waddr;
  logic [CHAR_W-1:0] txt_wdata;
  logic [ROW_W-1:0]  map_raddr, map_waddr, map_wdata, len_raddr, len_waddr;
  logic [COL_W-1:0]  len_wdata;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [LINES_W-1:0] total_r, total_nxt;
  logic               dirty_r, dirty_nxt, changed_r, changed_nxt;
  logic [CHAR_W-1:0]  rchar_r, rchar_nxt;
  logic [COL_W-1:0]   rlen_r, rlen_nxt;
  logic [ROW_W-1:0]   phys_a_r, phys_a_nxt, phys_b_r, phys_b_nxt;
  logic [COL_W-1:0]   len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic               merge_r, merge_nxt;
  logic [ROW_W-1:0]   ms_r, ms_nxt, md_r, md_nxt, mn_r, mn_nxt;
  logic               mdec_r, mdec_nxt;
  logic [ADDR_W-1:0]  cs_r, cs_nxt, cd_r, cd_nxt;
  logic [COL_W-1:0]   cn_r, cn_nxt;
  logic               cdec_r, cdec_nxt;
  logic               strobe_r, strobe_nxt;
  result_t            res_r, res_nxt;

  logic [ROW_W-1:0]   map_val, row_a, row_b;
  logic [COL_W-1:0]   len_val;
  logic               row_a_used, rd_hit;

  assign map_val = map_qv_r ? map_q_r : map_qa_r;
  assign len_val = len_qv_r ? len_q_r : '0;

  assign row_a      = (cmd_r.kind == K_READ) ? cmd_r.row : row_r;
  assign row_a_used = ({1'b0, row_a} < total_r);
  assign rd_hit     = row_a_used && (cmd_r.col < len_a_r);

  // Pick the second row: free slot for enter, previous or next line otherwise
  always_comb begin
    case (cmd_r.kind) inside
      K_ENTER:             row_b = total_r[ROW_W-1:0];
      K_LEFT, K_UP, K_BKSP: row_b = row_r - 1'b1;
      default:             row_b = row_r + 1'b1;
    endcase
  end

  // Sequence one request
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    total_nxt   = total_r;
    dirty_nxt   = dirty_r;
    changed_nxt = changed_r;
    rchar_nxt   = rchar_r;
    rlen_nxt    = rlen_r;
    phys_a_nxt  = phys_a_r;
    phys_b_nxt  = phys_b_r;
    len_a_nxt   = len_a_r;
    len_b_nxt   = len_b_r;
    merge_nxt   = merge_r;
    ms_nxt      = ms_r;
    md_nxt      = md_r;
    mn_nxt      = mn_r;
    mdec_nxt    = mdec_r;
    cs_nxt      = cs_r;
    cd_nxt      = cd_r;
    cn_nxt      = cn_r;
    cdec_nxt    = cdec_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    txt_we      = 1'b0;
    txt_raddr   = cs_r;
    txt_waddr   = cd_r;
    txt_wdata   = txt_q_r;
    map_we      = 1'b0;
    map_raddr   = ms_r;
    map_waddr   = md_r;
    map_wdata   = map_val;
    len_we      = 1'b0;
    len_clr     = 1'b0;
    len_raddr   = map_val;
    len_waddr   = phys_a_r;
    len_wdata   = len_a_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          changed_nxt = 1'b0;
          rchar_nxt   = '0;
          rlen_nxt    = '0;
          merge_nxt   = 1'b0;
          state_nxt   = S_P0;
        end
      end
      // fetch slot and length of both rows
      S_P0: begin
        map_raddr = row_a;
        state_nxt = S_P1;
      end
      S_P1: begin
        map_raddr  = row_b;
        phys_a_nxt = map_val;
        state_nxt  = S_P2;
      end
      S_P2: begin
        phys_b_nxt = map_val;
        len_a_nxt  = len_val;
        state_nxt  = S_P3;
      end
      S_P3: begin
        len_b_nxt = len_val;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (cmd_r.kind)
          K_ENTER: begin
            if (total_r < LINES_W'(MAX_LINES)) begin
              ms_nxt    = total_r[ROW_W-1:0] - 1'b1;
              md_nxt    = total_r[ROW_W-1:0];
              mn_nxt    = total_r[ROW_W-1:0] - 1'b1 - row_r;
              mdec_nxt  = 1'b1;
              cs_nxt    = {phys_a_r, col_r};
              cd_nxt    = {phys_b_r, {COL_W{1'b0}}};
              cn_nxt    = len_a_r - col_r;
              cdec_nxt  = 1'b0;
              state_nxt = S_MRD;
            end
          end
          K_BKSP: begin
            if (col_r != '0) begin
              cs_nxt    = {phys_a_r, col_r};
              cd_nxt    = {phys_a_r, col_r} - ADDR_W'(1);
              cn_nxt    = len_a_r - col_r;
              cdec_nxt  = 1'b0;
              state_nxt = S_CRD;
            end else if (row_r != '0 &&
                         ({1'b0, len_a_r} + {1'b0, len_b_r}) < (COL_W+1)'(LINE_CAPACITY)) begin
              merge_nxt = 1'b1;
              cs_nxt    = {phys_a_r, {COL_W{1'b0}}};
              cd_nxt    = {phys_b_r, len_b_r};
              cn_nxt    = len_a_r;
              cdec_nxt  = 1'b0;
              ms_nxt    = row_r + 1'b1;
              md_nxt    = row_r;
              mn_nxt    = total_r[ROW_W-1:0] - 1'b1 - row_r;
              mdec_nxt  = 1'b0;
              state_nxt = S_CRD;
            end
          end
          K_INS: begin
            if (len_a_r < COL_W'(LINE_CAPACITY-1)) begin
              cs_nxt    = {phys_a_r, len_a_r} - ADDR_W'(1);
              cd_nxt    = {phys_a_r, len_a_r};
              cn_nxt    = len_a_r - col_r;
              cdec_nxt  = 1'b1;
              state_nxt = S_CRD;
            end
          end
          K_LEFT: begin
            changed_nxt = 1'b1;
            if (col_r != '0) col_nxt = col_r - 1'b1;
            else if (row_r != '0) begin
              row_nxt = row_r - 1'b1;
              col_nxt = len_b_r;
            end
          end
          K_RIGHT: begin
            changed_nxt = 1'b1;
            if (col_r < len_a_r) col_nxt = col_r + 1'b1;
            else if (({1'b0, row_r} + 1'b1) < total_r) begin
              row_nxt = row_r + 1'b1;
              col_nxt = '0;
            end
          end
          K_UP: begin
            changed_nxt = 1'b1;
            if (row_r != '0) begin
              row_nxt = row_r - 1'b1;
              if (col_r > len_b_r) col_nxt = len_b_r;
            end
          end
          K_DOWN: begin
            changed_nxt = 1'b1;
            if (({1'b0, row_r} + 1'b1) < total_r) begin
              row_nxt = row_r + 1'b1;
              if (col_r > len_b_r) col_nxt = len_b_r;
            end
          end
          K_CLEAR: begin
            len_clr     = 1'b1;
            total_nxt   = LINES_W'(1);
            row_nxt     = '0;
            col_nxt     = '0;
            dirty_nxt   = 1'b0;
            changed_nxt = 1'b1;
          end
          K_READ: begin
            if (row_a_used) rlen_nxt = len_a_r;
            txt_raddr = {phys_a_r, cmd_r.col};
            state_nxt = S_RDW;
          end
          K_CLEAN: dirty_nxt = 1'b0;
          K_NOP:   ;
          default: ;
        endcase
      end
      S_RDW: begin
        if (rd_hit) rchar_nxt = txt_q_r;
        state_nxt = S_OUT;
      end
      // shift line map entries one at a time
      S_MRD: begin
        if (mn_r == '0) state_nxt = (cmd_r.kind == K_ENTER) ? S_CRD : S_FIN;
        else            state_nxt = S_MWR;
      end
      S_MWR: begin
        map_we    = 1'b1;
        ms_nxt    = mdec_r ? ms_r - 1'b1 : ms_r + 1'b1;
        md_nxt    = mdec_r ? md_r - 1'b1 : md_r + 1'b1;
        mn_nxt    = mn_r - 1'b1;
        state_nxt = S_MRD;
      end
      // move characters one at a time
      S_CRD: begin
        if (cn_r == '0) state_nxt = merge_r ? S_MRD : S_FIN;
        else            state_nxt = S_CWR;
      end
      S_CWR: begin
        txt_we    = 1'b1;
        cs_nxt    = cdec_r ? cs_r - 1'b1 : cs_r + 1'b1;
        cd_nxt    = cdec_r ? cd_r - 1'b1 : cd_r + 1'b1;
        cn_nxt    = cn_r - 1'b1;
        state_nxt = S_CRD;
      end
      S_FIN: begin
        dirty_nxt   = 1'b1;
        changed_nxt = 1'b1;
        len_we      = 1'b1;
        state_nxt   = S_OUT;
        unique case (cmd_r.kind)
          K_INS: begin
            txt_we    = 1'b1;
            txt_waddr = {phys_a_r, col_r};
            txt_wdata = cmd_r.ch;
            len_wdata = len_a_r + 1'b1;
            col_nxt   = col_r + 1'b1;
          end
          K_ENTER: begin
            map_we    = 1'b1;
            map_waddr = row_r + 1'b1;
            map_wdata = phys_b_r;
            len_waddr = phys_b_r;
            len_wdata = len_a_r - col_r;
            state_nxt = S_FIN2;
          end
          default: begin
            if (merge_r) begin
              map_we    = 1'b1;
              map_waddr = total_r[ROW_W-1:0] - 1'b1;
              map_wdata = phys_a_r;
              len_waddr = phys_b_r;
              len_wdata = len_a_r + len_b_r;
              total_nxt = total_r - 1'b1;
              row_nxt   = row_r - 1'b1;
              col_nxt   = len_b_r;
            end else begin
              len_wdata = len_a_r - 1'b1;
              col_nxt   = col_r - 1'b1;
            end
          end
        endcase
      end
      S_FIN2: begin
        len_we    = 1'b1;
        len_wdata = col_r;
        total_nxt = total_r + 1'b1;
        row_nxt   = row_r + 1'b1;
        col_nxt   = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        strobe_nxt               = 1'b1;
        res_nxt.changed          = changed_r;
        res_nxt.cursor_line      = row_r;
        res_nxt.cursor_column    = col_r;
        res_nxt.lines_in_use     = total_r;
        res_nxt.modified         = dirty_r;
        res_nxt.read_char        = rchar_r;
        res_nxt.read_line_length = rlen_r;
        state_nxt                = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      col_r    <= '0;
      total_r  <= LINES_W'(1);
      dirty_r  <= 1'b0;
      strobe_r <= 1'b0;
      merge_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      total_r  <= total_nxt;
      dirty_r  <= dirty_nxt;
      strobe_r <= strobe_nxt;
      merge_r  <= merge_nxt;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    changed_r <= changed_nxt;
    rchar_r   <= rchar_nxt;
    rlen_r    <= rlen_nxt;
    phys_a_r  <= phys_a_nxt;
    phys_b_r  <= phys_b_nxt;
    len_a_r   <= len_a_nxt;
    len_b_r   <= len_b_nxt;
    ms_r      <= ms_nxt;
    md_r      <= md_nxt;
    mn_r      <= mn_nxt;
    mdec_r    <= mdec_nxt;
    cs_r      <= cs_nxt;
    cd_r      <= cd_nxt;
    cn_r      <= cn_nxt;
    cdec_r    <= cdec_nxt;
    res_r     <= res_nxt;
  end

  // Track written map entries and lengths; unwritten map entries read as identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
      len_vld_r <= '0;
    end else begin
      if (map_we) map_vld_r[map_waddr] <= 1'b1;
      if (len_clr)     len_vld_r <= '0;
      else if (len_we) len_vld_r[len_waddr] <= 1'b1;
    end
  end

  // Text memory
  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_waddr] <= txt_wdata;
    txt_q_r <= txt_mem[txt_raddr];
  end

  // Line map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q_r  <= map_mem[map_raddr];
    map_qv_r <= map_vld_r[map_raddr];
    map_qa_r <= map_raddr;
  end

  // Line length memory
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_q_r  <= len_mem[len_raddr];
    len_qv_r <= len_vld_r[len_raddr];
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

>>> src/lte_checker.sv
// Port-level checks for the line text edit engine, bound to the top level.
module lte_port_checks (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_strobe,
  input logic                        out_changed,
  input logic [lte_pkg::ROW_W-1:0]   out_cursor_line,
  input logic [lte_pkg::LINES_W-1:0] out_lines_in_use,
  input logic [lte_pkg::CHAR_W-1:0]  out_read_char,
  input logic [lte_pkg::COL_W-1:0]   out_read_line_length
);
  import lte_pkg::*;

  // line count stays within the store
  a_lines_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_lines_in_use != '0 &&
                    out_lines_in_use <= LINES_W'(MAX_LINES)))
    else $error("line count out of range");

  // cursor sits on a line in use
  a_cursor_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_cursor_line} < out_lines_in_use))
    else $error("cursor past last line");

  // a read hit comes from a non-empty line and edits nothing
  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_read_char != '0) |->
      (out_read_line_length != '0 && !out_changed))
    else $error("read character without line");

  // one request at a time: results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results back to back");

endmodule

bind line_text_edit_engine lte_port_checks u_lte_port_checks (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_strobe           (out_strobe),
  .out_changed          (out_changed),
  .out_cursor_line      (out_cursor_line),
  .out_lines_in_use     (out_lines_in_use),
  .out_read_char        (out_read_char),
  .out_read_line_length (out_read_line_length)
);
